@@ src/pps_pkg.sv @@
package pps_pkg;

    localparam int COORD_W = 32;
    localparam int DIST_W  = 40;
    localparam int CNT_W   = 7;
    localparam int FRAC_W  = 30;
    localparam int PROD_W  = 48;

    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [15:0] M_ONE_Q14 = -16'sd16384;
    localparam logic [CNT_W-1:0]   CNT_SAT   = 7'd127;

    // configuration register indexes
    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_DIST     = 3'd3;
    localparam logic [2:0] REG_ON_BAND  = 3'd4;
    localparam logic [2:0] REG_CLIP     = 3'd5;

    typedef enum logic [1:0] {
        CLS_FRONT = 2'd0,
        CLS_BACK  = 2'd1,
        CLS_ON    = 2'd2
    } t_side;

    typedef enum logic [1:0] {
        CMD_POINT = 2'd0,
        CMD_CROSS = 2'd1,
        CMD_EMPTY = 2'd2
    } t_kind;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [31:0] offset;
        logic [30:0] band;
        logic        clip;
    } t_cfg;

    // one result to produce, handed from the classifier to the result unit
    typedef struct packed {
        t_kind             kind;
        t_point            p1;
        logic [DIST_W-1:0] d1;
        t_point            p2;
        logic [DIST_W-1:0] d2;
        logic              to_front;
        logic              to_back;
        logic              eop;
        logic [CNT_W-1:0]  cnt_front;
        logic [CNT_W-1:0]  cnt_back;
        logic [CNT_W-1:0]  cnt_on;
        logic              ovf;
    } t_cmd;

    // queue status seen by the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic opposite(input t_side a, input t_side b);
        return (a != CLS_ON) && (b != CLS_ON) && (a != b);
    endfunction

endpackage

@@ src/polygon_plane_split.sv @@
// Splits a polygon by a configured plane. Vertices arrive one per request,
// tlast on the final vertex. Each vertex is classed front, back or on the
// plane and the pieces' points stream out: vertex, then the crossing point
// on the edge to the next vertex; the closing edge is handled with the last
// vertex, whose final result carries tlast and the side counts. A vertex
// passes the classifier as accept, multiply, distance and four emit steps;
// an emit step waits while the queue is full. A dropped extra vertex is only
// accepted, or emitted too if last. A crossing point runs in the result unit
// as a pop, a one-bit-per-cycle division for the interpolation factor, three
// multiply and add step pairs and an output step; a vertex point is loaded at
// its pop. A short request queue lets classification run ahead of that unit.
module polygon_plane_split #(
    parameter int MAX_VERTS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic         s_axis_tlast,   // last_vertex
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,   // point_x, point_y, point_z, count_front,
                                         // count_back, count_on, too_many_vertices, pad
    output logic [1:0]   m_axis_tuser,   // to_front, to_back
    output logic         m_axis_tlast,   // end_of_polygon
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import pps_pkg::*;

    t_cfg    r_cfg;
    t_point  in_pt;
    logic    push, pop;
    t_cmd    f_cmd, q_cmd, res;
    t_qstat  qstat;

    assign o_cfg_ready = 1'b1;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nx     <= '0;
            r_cfg.ny     <= '0;
            r_cfg.nz     <= ONE_Q14;
            r_cfg.offset <= '0;
            r_cfg.band   <= 31'd6554;
            r_cfg.clip   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NORMAL_X: r_cfg.nx     <= i_cfg_data[15:0];
                REG_NORMAL_Y: r_cfg.ny     <= i_cfg_data[15:0];
                REG_NORMAL_Z: r_cfg.nz     <= i_cfg_data[15:0];
                REG_DIST:     r_cfg.offset <= i_cfg_data;
                REG_ON_BAND:  r_cfg.band   <= i_cfg_data[30:0];
                REG_CLIP:     r_cfg.clip   <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign in_pt.x = s_axis_tdata[31:0];
    assign in_pt.y = s_axis_tdata[63:32];
    assign in_pt.z = s_axis_tdata[95:64];

    pps_front #(.MAX_VERTS(MAX_VERTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pt    (in_pt),
        .i_last  (s_axis_tlast),
        .o_push  (push),
        .o_cmd   (f_cmd),
        .i_qstat (qstat)
    );

    pps_queue #(.DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_qstat (qstat)
    );

    pps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (q_cmd),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {2'b00, res.ovf, res.cnt_on, res.cnt_back, res.cnt_front,
                           res.p1.z, res.p1.y, res.p1.x};
    assign m_axis_tuser = {res.to_back, res.to_front};
    assign m_axis_tlast = res.eop;

    // no request is written into a full queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full) else $error("request queue overrun");

    // no request is taken from an empty queue
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty) else $error("request queue underrun");

    // counts and overflow flag appear only on the closing result
    a_counts_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[117:96] == '0))
        else $error("counts on a non-closing result");

    // a result in neither piece is the empty closing result
    a_empty_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == 2'b00) |-> (m_axis_tlast && m_axis_tdata[95:0] == '0))
        else $error("stray empty result");

endmodule

@@ src/pps_front.sv @@
module pps_front #(
    parameter int MAX_VERTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pps_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  pps_pkg::t_point  i_pt,
    input  logic             i_last,
    output logic             o_push,
    output pps_pkg::t_cmd    o_cmd,
    input  pps_pkg::t_qstat  i_qstat
);
    import pps_pkg::*;

    localparam int CW  = $clog2(MAX_VERTS + 1);
    localparam int CWX = (CW > CNT_W) ? CW : CNT_W;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIST, S_EMIT} t_state;

    t_state                    r_state;
    t_point                    r_cur;
    logic                      r_last;
    logic signed [PROD_W-1:0]  r_px, r_py, r_pz;
    logic [DIST_W-1:0]         r_d;
    t_side                     r_s;
    t_point                    r_first, r_prev;
    logic [DIST_W-1:0]         r_first_d, r_prev_d;
    t_side                     r_first_s, r_prev_s;
    logic [CW-1:0]             r_vcnt, r_cnt_f, r_cnt_b, r_cnt_o;
    logic                      r_ovf, r_skip;
    logic [3:0]                r_mask;
    logic [1:0]                r_k;

    logic signed [49:0]        sum, shv;
    logic signed [DIST_W-1:0]  d, band_s;
    t_side                     s, first_s_eff;
    logic                      c0, c1, c2, later_none, step_done;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CW-1:0] c);
        logic [CWX-1:0] e;
        e = CWX'(c);
        return (e > CWX'(CNT_SAT)) ? CNT_SAT : e[CNT_W-1:0];
    endfunction

    // distance to the plane and side of the current vertex
    always_comb begin
        sum    = 50'(r_px) + 50'(r_py) + 50'(r_pz);
        shv    = sum >>> 14;
        d      = DIST_W'(shv) - DIST_W'($signed(i_cfg.offset));
        band_s = {9'd0, i_cfg.band};
        if (d > band_s)       s = CLS_FRONT;
        else if (d < -band_s) s = CLS_BACK;
        else                  s = CLS_ON;
        first_s_eff = (r_vcnt == '0) ? s : r_first_s;
        c0 = (r_vcnt != '0) && opposite(r_prev_s, s);
        c1 = (s != CLS_FRONT) || !i_cfg.clip;
        c2 = r_last && opposite(s, first_s_eff);
    end

    // build the request for the current emit step
    always_comb begin
        case (r_k)
            2'd0:    later_none = (r_mask[3:1] == 3'd0);
            2'd1:    later_none = (r_mask[3:2] == 2'd0);
            2'd2:    later_none = !r_mask[3];
            default: later_none = 1'b1;
        endcase
        o_cmd          = '0;
        o_cmd.eop      = r_last && later_none;
        o_cmd.to_front = 1'b1;
        o_cmd.to_back  = 1'b1;
        unique case (r_k)
            2'd0: begin
                o_cmd.kind = CMD_CROSS;
                o_cmd.p1   = r_prev;
                o_cmd.d1   = r_prev_d;
                o_cmd.p2   = r_cur;
                o_cmd.d2   = r_d;
            end
            2'd1: begin
                o_cmd.kind     = CMD_POINT;
                o_cmd.p1       = r_cur;
                o_cmd.to_front = (r_s != CLS_BACK);
                o_cmd.to_back  = (r_s != CLS_FRONT);
            end
            2'd2: begin
                o_cmd.kind = CMD_CROSS;
                o_cmd.p1   = r_skip ? r_prev : r_cur;
                o_cmd.d1   = r_skip ? r_prev_d : r_d;
                o_cmd.p2   = r_first;
                o_cmd.d2   = r_first_d;
            end
            default: begin
                o_cmd.kind     = CMD_EMPTY;
                o_cmd.to_front = 1'b0;
                o_cmd.to_back  = 1'b0;
            end
        endcase
        if (o_cmd.eop) begin
            o_cmd.cnt_front = sat_cnt(r_cnt_f);
            o_cmd.cnt_back  = sat_cnt(r_cnt_b);
            o_cmd.cnt_on    = sat_cnt(r_cnt_o);
            o_cmd.ovf       = r_ovf;
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_push    = (r_state == S_EMIT) && r_mask[r_k] && !i_qstat.full;
    assign step_done = !r_mask[r_k] || !i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcnt    <= '0;
            r_cnt_f   <= '0;
            r_cnt_b   <= '0;
            r_cnt_o   <= '0;
            r_ovf     <= 1'b0;
            r_skip    <= 1'b0;
            r_mask    <= '0;
            r_k       <= '0;
            r_first   <= '0;
            r_first_d <= '0;
            r_first_s <= CLS_FRONT;
            r_prev    <= '0;
            r_prev_d  <= '0;
            r_prev_s  <= CLS_FRONT;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cur  <= i_pt;
                        r_last <= i_last;
                        r_k    <= '0;
                        if (r_vcnt >= CW'(MAX_VERTS)) begin
                            // drop the vertex, close the polygon if it is the last
                            r_ovf  <= 1'b1;
                            r_skip <= 1'b1;
                            if (i_last) begin
                                r_mask  <= {!opposite(r_prev_s, r_first_s),
                                            opposite(r_prev_s, r_first_s), 2'b00};
                                r_state <= S_EMIT;
                            end
                        end else begin
                            r_skip  <= 1'b0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_px    <= $signed(r_cur.x) * $signed(i_cfg.nx);
                    r_py    <= $signed(r_cur.y) * $signed(i_cfg.ny);
                    r_pz    <= $signed(r_cur.z) * $signed(i_cfg.nz);
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_d    <= d;
                    r_s    <= s;
                    r_mask <= {r_last && !(c0 || c1 || c2), c2, c1, c0};
                    if (r_vcnt == '0) begin
                        r_first   <= r_cur;
                        r_first_d <= d;
                        r_first_s <= s;
                    end
                    r_vcnt <= r_vcnt + 1'b1;
                    case (s)
                        CLS_FRONT: r_cnt_f <= r_cnt_f + 1'b1;
                        CLS_BACK:  r_cnt_b <= r_cnt_b + 1'b1;
                        default:   r_cnt_o <= r_cnt_o + 1'b1;
                    endcase
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (step_done) begin
                        r_k <= r_k + 1'b1;
                        if (r_k == 2'd3) begin
                            if (!r_skip) begin
                                r_prev   <= r_cur;
                                r_prev_d <= r_d;
                                r_prev_s <= r_s;
                            end
                            if (r_last) begin
                                r_vcnt  <= '0;
                                r_cnt_f <= '0;
                                r_cnt_b <= '0;
                                r_cnt_o <= '0;
                                r_ovf   <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/pps_queue.sv @@
module pps_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pps_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output pps_pkg::t_cmd    o_cmd,
    output pps_pkg::t_qstat  o_qstat
);
    import pps_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt;

    assign o_cmd         = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    // store requests
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

@@ src/pps_back.sv @@
module pps_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pps_pkg::t_cfg    i_cfg,
    input  pps_pkg::t_cmd    i_cmd,
    input  pps_pkg::t_qstat  i_qstat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output pps_pkg::t_cmd    o_res
);
    import pps_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_MUL, B_ADD, B_OUT} t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [DIST_W:0]      r_rem;
    logic [DIST_W-1:0]    r_den;
    logic [FRAC_W-1:0]    r_t;
    logic [4:0]           r_i;
    logic [1:0]           r_j;
    logic [61:0]          r_prod;
    logic                 r_neg;
    t_point               r_mid;
    logic                 r_ovalid;
    t_cmd                 r_out;

    logic                 out_free;
    logic                 load_out;
    t_cmd                 pt_res, cr_res;
    logic [DIST_W-1:0]    a1, a2;
    logic [DIST_W:0]      rem2;
    logic signed [COORD_W-1:0] c1, c2, cres;
    logic signed [COORD_W:0]   delta, mid;
    logic [COORD_W-1:0]   mag, off;
    logic [15:0]          nsel;
    logic [61:0]          rnd;

    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = (r_state == B_IDLE) && !i_qstat.empty && out_free;
    assign o_valid  = r_ovalid;
    assign o_res    = r_out;

    // magnitudes of the edge end distances
    always_comb begin
        a1   = $signed(i_cmd.d1) < 0 ? -i_cmd.d1 : i_cmd.d1;
        a2   = $signed(i_cmd.d2) < 0 ? -i_cmd.d2 : i_cmd.d2;
        rem2 = {r_rem[DIST_W-1:0], 1'b0};
    end

    // results loaded into the output register
    always_comb begin
        pt_res = i_cmd;
        if (i_cmd.kind == CMD_POINT && i_cfg.clip) begin
            pt_res.to_front = 1'b0;
            pt_res.to_back  = 1'b1;
        end
        cr_res          = r_cmd;
        cr_res.p1       = r_mid;
        cr_res.to_front = !i_cfg.clip;
        cr_res.to_back  = 1'b1;
        load_out = (o_pop && i_cmd.kind != CMD_CROSS) || (r_state == B_OUT && out_free);
    end

    // select the coordinate of the current interpolation step
    always_comb begin
        case (r_j)
            2'd0:    begin c1 = r_cmd.p1.x; c2 = r_cmd.p2.x; nsel = i_cfg.nx; end
            2'd1:    begin c1 = r_cmd.p1.y; c2 = r_cmd.p2.y; nsel = i_cfg.ny; end
            default: begin c1 = r_cmd.p1.z; c2 = r_cmd.p2.z; nsel = i_cfg.nz; end
        endcase
        delta = (COORD_W+1)'(c2) - (COORD_W+1)'(c1);
        mag   = delta[COORD_W] ? COORD_W'(-delta) : delta[COORD_W-1:0];
        rnd   = r_prod + (62'd1 << (FRAC_W - 1));
        off   = rnd[FRAC_W +: COORD_W];
        mid   = r_neg ? (COORD_W+1)'(c1) - (COORD_W+1)'(off)
                      : (COORD_W+1)'(c1) + (COORD_W+1)'(off);
        if ($signed(nsel) == ONE_Q14)
            cres = $signed(i_cfg.offset);
        else if ($signed(nsel) == M_ONE_Q14)
            cres = (i_cfg.offset == 32'h8000_0000) ? 32'sh7FFF_FFFF : -$signed(i_cfg.offset);
        else
            cres = mid[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= load_out || (r_ovalid && !i_ready);
            if (load_out) r_out <= (r_state == B_OUT) ? cr_res : pt_res;
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.kind == CMD_CROSS) begin
                            // start the interpolation factor division
                            r_rem   <= {1'b0, a1};
                            r_den   <= a1 + a2;
                            r_t     <= '0;
                            r_i     <= '0;
                            r_state <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    // one quotient bit per cycle
                    if (r_den != '0 && rem2 >= {1'b0, r_den}) begin
                        r_rem <= rem2 - {1'b0, r_den};
                        r_t   <= {r_t[FRAC_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem2;
                        r_t   <= {r_t[FRAC_W-2:0], 1'b0};
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == 5'(FRAC_W - 1)) begin
                        r_j     <= '0;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_prod  <= 62'(mag) * 62'(r_t);
                    r_neg   <= delta[COORD_W];
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    case (r_j)
                        2'd0:    r_mid.x <= cres;
                        2'd1:    r_mid.y <= cres;
                        default: r_mid.z <= cres;
                    endcase
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j == 2'd2) ? B_OUT : B_MUL;
                end
                B_OUT: begin
                    if (out_free) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
